/* hdl/fpef_pkg.sv */
// Shared constants for the filtered peak envelope follower.
// Configuration register indexes and Q0.24 coefficient defaults; no dependencies.
`default_nettype none

package fpef_pkg;

  // Width of the configuration register index
  localparam int CFG_IDX_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_HIGHPASS = 2'd0,
    CFG_LOWPASS  = 2'd1,
    CFG_DECAY    = 2'd2
  } cfg_index_t;

  // Coefficient defaults are given with this many fraction bits
  localparam int DEFAULT_FRAC_BITS = 24;

  localparam logic [DEFAULT_FRAC_BITS-1:0] HIGHPASS_DEFAULT = 24'd16560440;
  localparam logic [DEFAULT_FRAC_BITS-1:0] LOWPASS_DEFAULT  = 24'd12912836;
  localparam logic [DEFAULT_FRAC_BITS-1:0] DECAY_DEFAULT    = 24'd16777048;

endpackage

`default_nettype wire

/* hdl/fpef_if.sv */
// Valid/ready stream interfaces for the envelope follower: sample beats in,
// envelope beats out. No dependencies.
`default_nettype none

interface fpef_sample_if #(
  parameter int SAMPLE_WIDTH = 24
);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] sample_in;

  modport source (output valid, output sample_in, input ready);
  modport sink   (input valid, input sample_in, output ready);
endinterface

interface fpef_env_if #(
  parameter int SAMPLE_WIDTH = 24
);
  logic                    valid;
  logic                    ready;
  logic [SAMPLE_WIDTH-2:0] envelope_out;

  modport source (output valid, output envelope_out, input ready);
  modport sink   (input valid, input envelope_out, output ready);
endinterface

`default_nettype wire

/* hdl/filtered_peak_envelope_follower.sv */
// Filtered peak envelope follower: high-pass, low-pass and peak/decay stages
// sharing one multiplier. Depends on fpef_pkg and the interfaces in fpef_if.sv.
`default_nettype none

// One sample beat produces one envelope beat. All three products (high-pass,
// low-pass and decay) go through a single multiplier under a small sequencer.
// The envelope enters the output register from the hand-over state, reached
// through the high-pass and low-pass steps and, when the low-pass value sets no
// new peak, the decay step; no new sample is taken until the sequencer is idle.
// The output register frees the input side, so the next sample is taken while
// an envelope waits to be read; that sample then holds in its hand-over state
// until the waiting envelope has gone. Coefficients are unsigned
// Q0.COEFF_FRAC_BITS and should be written only while the block is idle.
module filtered_peak_envelope_follower
  import fpef_pkg::*;
#(
  parameter int SAMPLE_WIDTH    = 24,
  parameter int COEFF_FRAC_BITS = 24
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  fpef_sample_if.sink                     in_ch,
  fpef_env_if.source                      out_ch,
  input  wire logic                       cfg_we,
  input  wire logic [CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [COEFF_FRAC_BITS-1:0] cfg_data
);

  localparam int SW     = SAMPLE_WIDTH;
  localparam int CFB    = COEFF_FRAC_BITS;
  localparam int MAG_W  = SW + 1;
  localparam int PROD_W = MAG_W + CFB;

  localparam logic [63:0] HP_DEF64 = (CFB >= DEFAULT_FRAC_BITS) ?
      (64'(HIGHPASS_DEFAULT) << (CFB - DEFAULT_FRAC_BITS)) :
      (64'(HIGHPASS_DEFAULT) >> (DEFAULT_FRAC_BITS - CFB));
  localparam logic [63:0] LP_DEF64 = (CFB >= DEFAULT_FRAC_BITS) ?
      (64'(LOWPASS_DEFAULT) << (CFB - DEFAULT_FRAC_BITS)) :
      (64'(LOWPASS_DEFAULT) >> (DEFAULT_FRAC_BITS - CFB));
  localparam logic [63:0] DC_DEF64 = (CFB >= DEFAULT_FRAC_BITS) ?
      (64'(DECAY_DEFAULT) << (CFB - DEFAULT_FRAC_BITS)) :
      (64'(DECAY_DEFAULT) >> (DEFAULT_FRAC_BITS - CFB));

  localparam logic [PROD_W-1:0] HALF = {{(PROD_W-1){1'b0}}, 1'b1} << (CFB - 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_HP,
    ST_HP_FIN,
    ST_MUL_LP,
    ST_LP_FIN,
    ST_MUL_DEC,
    ST_DEC_FIN,
    ST_OUT
  } state_t;

  function automatic logic signed [SW-1:0] sat_sample(input logic signed [SW+1:0] v);
    logic signed [SW-1:0] res;
    if ((v[SW+1:SW-1] == 3'b000) || (v[SW+1:SW-1] == 3'b111)) begin
      res = v[SW-1:0];
    end else if (v[SW+1]) begin
      res = {1'b1, {(SW-1){1'b0}}};
    end else begin
      res = {1'b0, {(SW-1){1'b1}}};
    end
    return res;
  endfunction

  function automatic logic [MAG_W-1:0] magnitude(input logic signed [SW+1:0] v);
    logic signed [SW+1:0] a;
    a = v[SW+1] ? -v : v;
    return a[MAG_W-1:0];
  endfunction

  // Configuration registers
  logic [CFB-1:0] hp_coeff_r;
  logic [CFB-1:0] lp_coeff_r;
  logic [CFB-1:0] decay_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hp_coeff_r <= HP_DEF64[CFB-1:0];
      lp_coeff_r <= LP_DEF64[CFB-1:0];
      decay_r    <= DC_DEF64[CFB-1:0];
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_HIGHPASS: hp_coeff_r <= cfg_data;
        CFG_LOWPASS:  lp_coeff_r <= cfg_data;
        CFG_DECAY:    decay_r    <= cfg_data;
        default: ;
      endcase
    end
  end

  state_t                state_r, state_nxt;
  logic [MAG_W-1:0]      op_a_r, op_a_nxt;
  logic                  neg_r, neg_nxt;
  logic [PROD_W-1:0]     prod_r, prod_nxt;
  logic signed [SW-1:0]  h_r, h_nxt;
  logic signed [SW-1:0]  hp_in_r, hp_in_nxt;
  logic signed [SW-1:0]  hp_out_r, hp_out_nxt;
  logic signed [SW-1:0]  lp_out_r, lp_out_nxt;
  logic [SW-2:0]         env_r, env_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [SW-2:0]         out_data_r, out_data_nxt;

  // Shared multiplier; the coefficient follows the sequencer state
  logic [CFB-1:0]        coef_sel;
  logic [PROD_W-1:0]     prod_mul;

  always_comb begin
    case (state_r)
      ST_MUL_HP: coef_sel = hp_coeff_r;
      ST_MUL_LP: coef_sel = lp_coeff_r;
      default:   coef_sel = decay_r;
    endcase
  end

  assign prod_mul = op_a_r * coef_sel;

  // Rounding, sign restore and saturation of the registered product
  logic [PROD_W-1:0]     rnd_sum;
  logic [MAG_W-1:0]      rnd_q;
  logic signed [SW+1:0]  signed_q;
  logic signed [SW-1:0]  hp_sat;
  logic signed [SW+1:0]  lp_sum;
  logic signed [SW-1:0]  lp_sat;
  logic signed [SW+1:0]  hp_diff;
  logic signed [SW+1:0]  lp_diff;

  assign rnd_sum  = prod_r + ((state_r == ST_DEC_FIN) ? {PROD_W{1'b0}} : HALF);
  assign rnd_q    = rnd_sum[CFB +: MAG_W];
  assign signed_q = neg_r ? -$signed({1'b0, rnd_q}) : $signed({1'b0, rnd_q});
  assign hp_sat   = sat_sample(signed_q);
  assign lp_sum   = $signed({{2{h_r[SW-1]}}, h_r}) + signed_q;
  assign lp_sat   = sat_sample(lp_sum);

  assign hp_diff = $signed({{2{hp_out_r[SW-1]}}, hp_out_r})
                 + $signed({{2{in_ch.sample_in[SW-1]}}, in_ch.sample_in})
                 - $signed({{2{hp_in_r[SW-1]}}, hp_in_r});
  assign lp_diff = $signed({{2{lp_out_r[SW-1]}}, lp_out_r})
                 - $signed({{2{hp_sat[SW-1]}}, hp_sat});

  always_comb begin
    state_nxt     = state_r;
    op_a_nxt      = op_a_r;
    neg_nxt       = neg_r;
    prod_nxt      = prod_r;
    h_nxt         = h_r;
    hp_in_nxt     = hp_in_r;
    hp_out_nxt    = hp_out_r;
    lp_out_nxt    = lp_out_r;
    env_nxt       = env_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_ch.valid) begin
          hp_in_nxt = in_ch.sample_in;
          op_a_nxt  = magnitude(hp_diff);
          neg_nxt   = hp_diff[SW+1];
          state_nxt = ST_MUL_HP;
        end
      end
      ST_MUL_HP: begin
        prod_nxt  = prod_mul;
        state_nxt = ST_HP_FIN;
      end
      ST_HP_FIN: begin
        h_nxt      = hp_sat;
        hp_out_nxt = hp_sat;
        op_a_nxt   = magnitude(lp_diff);
        neg_nxt    = lp_diff[SW+1];
        state_nxt  = ST_MUL_LP;
      end
      ST_MUL_LP: begin
        prod_nxt  = prod_mul;
        state_nxt = ST_LP_FIN;
      end
      ST_LP_FIN: begin
        lp_out_nxt = lp_sat;
        // A negative low-pass value never beats the envelope
        if (lp_sat > $signed({1'b0, env_r})) begin
          env_nxt   = lp_sat[SW-2:0];
          state_nxt = ST_OUT;
        end else begin
          op_a_nxt  = {2'b00, env_r};
          neg_nxt   = 1'b0;
          state_nxt = ST_MUL_DEC;
        end
      end
      ST_MUL_DEC: begin
        prod_nxt  = prod_mul;
        state_nxt = ST_DEC_FIN;
      end
      ST_DEC_FIN: begin
        // Truncated, so the envelope always falls to zero eventually
        env_nxt   = rnd_q[SW-2:0];
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = env_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      hp_in_r     <= '0;
      hp_out_r    <= '0;
      lp_out_r    <= '0;
      env_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      hp_in_r     <= hp_in_nxt;
      hp_out_r    <= hp_out_nxt;
      lp_out_r    <= lp_out_nxt;
      env_r       <= env_nxt;
      out_valid_r <= out_valid_nxt;
    end
    op_a_r     <= op_a_nxt;
    neg_r      <= neg_nxt;
    prod_r     <= prod_nxt;
    h_r        <= h_nxt;
    out_data_r <= out_data_nxt;
  end

  assign in_ch.ready         = (state_r == ST_IDLE);
  assign out_ch.valid        = out_valid_r;
  assign out_ch.envelope_out = out_data_r;

  // Once a beat is taken, the sequencer is busy on the following cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("input accepted twice in a row");

  // The decay path can only lower the envelope.
  a_decay_falls: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DEC_FIN) |=> (env_r <= $past(env_r)))
    else $error("envelope rose on the decay path");

  // A result beat is only raised when the sequencer hands one over.
  a_valid_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_OUT))
    else $error("output valid raised outside the hand-over state");

  // The delivered envelope matches the held state.
  a_out_matches_env: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_OUT) && (!out_valid_r || out_ch.ready)) |=> (out_data_r == env_r))
    else $error("output data differs from envelope state");

endmodule

`default_nettype wire
